// ----- hdl/double_ended_queue_assert.svh -----
// Assertion helpers for the double-ended queue.
// Each macro checks a property on the rising clock edge and is disabled while reset is low.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// The property must hold at every clock edge.
`define DQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger is true, the condition must hold in the next cycle.
`define DQ_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ----- hdl/dq_pkg.sv -----
package dq_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_BITS  = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  localparam int IN_BITS     = CMD_W + WORD_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = WORD_BITS + STATUS_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [WORD_BITS-1:0] dq_word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PEEK_FRONT = 3'd2,
    CMD_PEEK_BACK  = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_POP_BACK   = 3'd5,
    CMD_REVERSE    = 3'd6
  } dq_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_LOAD
  } dq_cell_op_t;

  typedef struct packed {
    dq_cell_op_t op;
    dq_word_t    push_word;
  } dq_cell_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill_count;
    dq_status_t       status;
    dq_word_t         read_value;
  } dq_result_t;

endpackage

// ----- hdl/double_ended_queue.sv -----
// A result is registered in the output buffer when its command transfer is taken.
// One command per cycle unless the output buffer is full; cells shift or load in one step.
// A two-entry output buffer keeps taking commands while one result waits to be taken.
// Reset (rst_n low, synchronous) empties the queue, sets normal orientation and drops
// pending results; the storage cells are not cleared.
`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] cmd, [34:3] push_value, upper bits zero
  input  logic [dq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [31:0] read_value, [33:32] status, [38:34] fill_count, upper bits zero
  output logic [dq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dq_pkg::*;

  // Queue bookkeeping. Cell 0 is the physical front; the occupied cells are
  // 0 .. count-1. The orientation flag swaps which physical end is the logical front.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;

  logic             in_xfer;
  dq_cmd_t          cmd;
  dq_word_t         push_value;
  logic             logical_front;
  logic             phys_front;
  logic             is_empty;
  logic             is_full;
  logic             is_push;
  logic             shift_up;
  logic             shift_down;
  logic             load_back;
  dq_word_t         tail_word;
  dq_result_t       result;
  dq_result_t       out_res;

  dq_word_t         cell_q    [CAPACITY];
  dq_cell_ctrl_t    cell_ctrl [CAPACITY];

  assign in_xfer    = in_tvalid && in_tready;
  assign cmd        = dq_cmd_t'(in_tdata[CMD_W-1:0]);
  assign push_value = in_tdata[CMD_W+WORD_BITS-1:CMD_W];

  assign logical_front = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PEEK_FRONT) ||
                         (cmd == CMD_POP_FRONT);
  assign phys_front    = logical_front ^ rev_r;
  assign is_empty      = (count_r == '0);
  assign is_full       = (count_r == CNT_W'(CAPACITY));
  assign is_push       = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_BACK);

  // Last occupied cell, picked by a one-hot match on the count.
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        tail_word = tail_word | cell_q[i];
      end
    end
  end

  // Decode the command into chain moves and the result.
  always_comb begin
    count_nxt          = count_r;
    rev_nxt            = rev_r;
    shift_up           = 1'b0;
    shift_down         = 1'b0;
    load_back          = 1'b0;
    result.read_value  = '0;
    result.status      = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (is_full) begin
          result.status = ST_FULL;
        end else begin
          shift_up  = phys_front;
          load_back = !phys_front;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (is_empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.read_value = phys_front ? cell_q[0] : tail_word;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (is_empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.read_value = phys_front ? cell_q[0] : tail_word;
          shift_down        = phys_front;
          count_nxt         = count_r - 1'b1;
        end
      end
      CMD_REVERSE: begin
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase
    result.fill_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (in_xfer) begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // The chain: every cell gets its move; cell 0 takes the pushed word on a front push,
  // the last cell keeps its word on a front pop.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dq_word_t left_w;
    dq_word_t right_w;

    if (g == 0) begin : g_first
      assign left_w = push_value;
    end else begin : g_inner_l
      assign left_w = cell_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_inner_r
      assign right_w = cell_q[g+1];
    end

    always_comb begin
      cell_ctrl[g].push_word = push_value;
      if (!in_xfer) begin
        cell_ctrl[g].op = CELL_HOLD;
      end else if (shift_up) begin
        cell_ctrl[g].op = CELL_SHIFT_UP;
      end else if (shift_down) begin
        cell_ctrl[g].op = CELL_SHIFT_DOWN;
      end else if (load_back && (count_r == CNT_W'(g))) begin
        cell_ctrl[g].op = CELL_LOAD;
      end else begin
        cell_ctrl[g].op = CELL_HOLD;
      end
    end

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_word  (left_w),
      .right_word (right_w),
      .word_q     (cell_q[g])
    );
  end

  // Hold each result until its transfer on the output side.
  dq_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (in_tvalid),
    .wr_data   (result),
    .wr_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_res.fill_count,
                      out_res.status, out_res.read_value};

  `DQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `DQ_ASSERT_NEXT(a_push_grows, clk, rst_n, in_xfer && is_push && !is_full, count_r == $past(count_r) + 1'b1, "accepted push did not grow the queue")
  `DQ_ASSERT_NEXT(a_full_push_holds, clk, rst_n, in_xfer && is_push && is_full, $stable(count_r), "refused push changed the count")
  `DQ_ASSERT(a_empty_read, clk, rst_n, !(in_xfer && is_empty && (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK || cmd == CMD_PEEK_FRONT || cmd == CMD_PEEK_BACK)) || (result.status == ST_EMPTY && result.read_value == '0), "read of empty queue not flagged")

endmodule

// ----- hdl/dq_cell.sv -----
module dq_cell (
  input  logic                  clk,
  input  dq_pkg::dq_cell_ctrl_t ctrl,
  input  dq_pkg::dq_word_t      left_word,
  input  dq_pkg::dq_word_t      right_word,
  output dq_pkg::dq_word_t      word_q
);
  import dq_pkg::*;

  dq_word_t word_r;
  dq_word_t word_nxt;

  // One slot of the chain: take from the front-side neighbour, the back-side neighbour,
  // the pushed word, or hold.
  always_comb begin
    case (ctrl.op)
      CELL_SHIFT_UP:   word_nxt = left_word;
      CELL_SHIFT_DOWN: word_nxt = right_word;
      CELL_LOAD:       word_nxt = ctrl.push_word;
      default:         word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;

endmodule

// ----- hdl/dq_outbuf.sv -----
module dq_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  input  dq_pkg::dq_result_t wr_data,
  output logic               wr_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dq_pkg::dq_result_t out_data
);
  import dq_pkg::*;

  logic       main_valid_r, main_valid_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  dq_result_t main_r, main_nxt;
  dq_result_t skid_r, skid_nxt;
  logic       take;
  logic       wr;

  assign wr_ready = !skid_valid_r;
  assign wr       = wr_valid && wr_ready;
  assign take     = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (take) begin
      if (skid_valid_r) begin
        // advance the skid entry; no write can arrive while it is full
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (wr) begin
        main_nxt = wr_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (wr) begin
      if (!main_valid_r) begin
        main_nxt       = wr_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = wr_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ----- test/double_ended_queue_tb.sv -----
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_GAP      = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 6;

  // Code 7 is not decoded by the block; it must pass through as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  // [2:0] cmd, [34:3] push_value, upper bits zero
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  // [31:0] read_value, [33:32] status, [38:34] fill_count, upper bits zero
  logic [OUT_TDATA_W-1:0]  out_tdata;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock, period 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: ring of words, physical front index, count and orientation.
  // Updated once per accepted command transfer, in transfer order.
  // ---------------------------------------------------------------------------
  dq_word_t         ring_words [CAPACITY];
  logic [IDX_W-1:0] head_idx;
  logic [CNT_W-1:0] word_count;
  logic             reversed;

  dq_result_t pending_results [$];

  // Run bookkeeping.
  int  error_count;
  int  cycle_count;
  int  commands_sent;
  int  results_checked;
  int  full_refusals;
  int  empty_answers;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  rx_hold_request;

  // Apply one command to the shadow deque and return the result it must give.
  function automatic dq_result_t next_deque_result(logic [CMD_W-1:0] cmd, dq_word_t value);
    dq_result_t       res;
    logic             logical_front;
    logic             phys_front;
    logic [IDX_W-1:0] pos;
    res.read_value = '0;
    res.status     = ST_OK;
    logical_front  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PEEK_FRONT) ||
                     (cmd == CMD_POP_FRONT);
    // With the orientation flipped, the logical front is the physical back.
    phys_front     = logical_front ^ reversed;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (word_count == CNT_W'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          if (phys_front) begin
            head_idx = head_idx - 1'b1;
            ring_words[head_idx] = value;
          end else begin
            pos = head_idx + IDX_W'(word_count);
            ring_words[pos] = value;
          end
          word_count = word_count + 1'b1;
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK: begin
        if (word_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = phys_front ? head_idx : head_idx + IDX_W'(word_count - 1'b1);
          res.read_value = ring_words[pos];
          if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            if (phys_front) head_idx = head_idx + 1'b1;
            word_count = word_count - 1'b1;
          end
        end
      end
      CMD_REVERSE: reversed = ~reversed;
      default: ;
    endcase
    res.fill_count = word_count;
    return res;
  endfunction

  // Random word, with the extremes drawn now and then.
  function automatic dq_word_t random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return dq_word_t'($urandom);
    endcase
  endfunction

  // Random command; push_pct sets how strongly the walk drifts towards full.
  function automatic logic [CMD_W-1:0] random_cmd(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2)  return CMD_UNUSED;
    if (roll < 10) return CMD_REVERSE;
    if (roll < 10 + (push_pct * 90) / 100)
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    case ($urandom_range(0, 4))
      0:       return CMD_PEEK_FRONT;
      1:       return CMD_PEEK_BACK;
      2, 3:    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      default: return CMD_POP_FRONT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command side. Enter only just after a rising edge; leave with tvalid high
  // right after the accepting edge, so a back-to-back command keeps it high.
  // ---------------------------------------------------------------------------
  task automatic send_command(logic [CMD_W-1:0] cmd, dq_word_t value);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({value, cmd});
    do @(posedge clk); while (!in_tready);
    // Transfer taken: predict now, in acceptance order.
    pending_results.push_back(next_deque_result(cmd, value));
    commands_sent++;
  endtask

  // Stop offering and hold until every expected result has been taken.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: draw a stall before each result; honour a long hold-off when
  // one is requested.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_request) @(posedge clk);
        rx_hold_request = 0;
      end
      stall = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    dq_result_t got;
    dq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = dq_result_t'(out_tdata[OUT_BITS-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: read_value %0d status %0d fill %0d",
                 $time, got.read_value, got.status, got.fill_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == ST_FULL)  full_refusals++;
        if (want.status == ST_EMPTY) empty_answers++;
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d, actual %0d",
                   $time, want.read_value, got.read_value);
          error_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, got.status);
          error_count++;
        end
        if (got.fill_count !== want.fill_count) begin
          $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                   $time, want.fill_count, got.fill_count);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:OUT_BITS] !== '0) begin
          $display("%0t: tdata padding mismatch: expected 0, actual %0h",
                   $time, out_tdata[OUT_TDATA_W-1:OUT_BITS]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every read on an empty queue reports empty; reverse and the unused code
  // are harmless no-ops.
  task automatic test_empty_queue();
    send_command(CMD_PEEK_FRONT, random_word());
    send_command(CMD_PEEK_BACK,  random_word());
    send_command(CMD_POP_FRONT,  random_word());
    send_command(CMD_POP_BACK,   random_word());
    send_command(CMD_REVERSE,    random_word());
    send_command(CMD_UNUSED,     random_word());
    wait_for_drain();
  endtask

  // Extreme words at both ends, fill to capacity, refuse pushes at both ends,
  // then read both ends either side of a reverse.
  task automatic test_fill_and_extremes();
    send_command(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_command(CMD_PUSH_BACK,  32'sh7FFF_FFFF);
    send_command(CMD_PUSH_FRONT, -32'sd1);
    send_command(CMD_PUSH_BACK,  '0);
    while (word_count < CNT_W'(CAPACITY))
      send_command($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_word());
    send_command(CMD_PUSH_FRONT, random_word());
    send_command(CMD_PUSH_BACK,  random_word());
    send_command(CMD_PEEK_FRONT, random_word());
    send_command(CMD_PEEK_BACK,  random_word());
    send_command(CMD_REVERSE,    random_word());
    send_command(CMD_PEEK_FRONT, random_word());
    send_command(CMD_POP_FRONT,  random_word());
    send_command(CMD_POP_BACK,   random_word());
    wait_for_drain();
  endtask

  // Random walks in bursts that drift strongly towards full, drift mildly towards full, or drift
  // towards empty, so both boundaries are hit many times with idling on.
  task automatic test_random_traffic(int bursts);
    int bias [3] = '{85, 50, 15};
    for (int b = 0; b < bursts; b++) begin
      for (int i = 0; i < 40; i++)
        send_command(random_cmd(bias[b % 3]), random_word());
      // Pause now and then until every result is back.
      if (b % 5 == 4) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // Hold the result side off for a long stretch while commands keep coming,
  // so the output buffer fills and the block stalls its input.
  task automatic test_back_pressure();
    tx_idle_en      = 1'b0;
    rx_hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++)
      send_command(random_cmd(50), random_word());
    wait_for_drain();
    tx_idle_en = 1'b1;
  endtask

  // Full rate on both sides: no idling anywhere.
  task automatic test_full_rate(int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < count; i++)
      send_command(random_cmd((i / 30) % 2 ? 20 : 80), random_word());
    wait_for_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    head_idx        = '0;
    word_count      = '0;
    reversed        = 1'b0;
    error_count     = 0;
    cycle_count     = 0;
    commands_sent   = 0;
    results_checked = 0;
    full_refusals   = 0;
    empty_answers   = 0;
    rx_hold_request = 0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_extremes();
    test_random_traffic(15);
    test_back_pressure();
    test_full_rate(160);

    $display("Run covered %0d commands and %0d checked results", commands_sent,
             results_checked);
    $display("including %0d refused pushes and %0d empty reads", full_refusals,
             empty_answers);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
